// ===== rtl/dfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types, codes and constants of the topological sorter.
// ----------------------------------------------------------------------------
package dfs_pkg;

	localparam int ID_SPAN = 32;
	localparam int MAX_VERTICES_DEF = 32;
	localparam int ID_W = 5;

	typedef enum logic [1:0] {
		OP_ADD_VERTEX = 2'd0,
		OP_ADD_EDGE   = 2'd1,
		OP_RUN        = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EXISTS  = 2'd1,
		ST_MISSING = 2'd2,
		ST_CYCLIC  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_ROOT,
		S_STEP,
		S_EMIT,
		S_CYC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the input word
		logic apply;      // update the graph store for an add word
		logic walk_init;  // clear marks and counters
		logic root_next;  // advance the root scan, push root if unvisited
		logic step;       // one walk step on the stack top
		logic emit_next;  // move to the next finish entry
	} dfs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic root_done;
		logic stack_empty;
		logic cycle;
		logic emit_done;
		logic none_finished;
	} dfs_stat_t;

endpackage

// ===== rtl/dfs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_in_if / dfs_out_if
// Valid-ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface dfs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [4:0] vertex_a;
	logic [4:0] vertex_b;
	modport source (output valid, op, vertex_a, vertex_b, input ready);
	modport sink (input valid, op, vertex_a, vertex_b, output ready);
endinterface

interface dfs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] vertex_out;
	logic       last;
	modport source (output valid, status, vertex_out, last, input ready);
	modport sink (input valid, status, vertex_out, last, output ready);
endinterface

// ===== rtl/dfs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_datapath
// Graph store, walk stack, marks and finish list of the sorter.
// ----------------------------------------------------------------------------
module dfs_datapath import dfs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dfs_cmd_t        cmd,
	output dfs_stat_t       stat,
	input  logic [1:0]      op,
	input  logic [ID_W-1:0] vertex_a,
	input  logic [ID_W-1:0] vertex_b,
	output logic [1:0]      status,
	output logic [ID_W-1:0] vertex_out
);

	localparam int LIMIT = (MAX_VERTICES < ID_SPAN) ? MAX_VERTICES : ID_SPAN;

	logic [ID_SPAN-1:0] present_q;
	logic [ID_SPAN-1:0] adj_q [ID_SPAN];
	logic [ID_SPAN-1:0] visited_q, on_path_q;
	logic [ID_W-1:0]    stk_v_q [ID_SPAN];
	logic [ID_W:0]      stk_n_q [ID_SPAN];
	logic [ID_W:0]      depth_q;
	logic [ID_W-1:0]    fin_q [ID_SPAN];
	logic [ID_W:0]      fin_cnt_q;
	logic [ID_W:0]      root_q;
	logic [ID_W:0]      emit_q;
	logic [1:0]         op_q;
	logic [ID_W-1:0]    a_q, b_q;
	logic [1:0]         status_q;

	logic a_ok, b_ok, a_pres, b_pres;
	logic [ID_W-1:0] top;
	logic [ID_W-1:0] v;
	logic [ID_W:0]   nxt;
	logic [ID_SPAN-1:0] cand;
	logic            found;
	logic [ID_W-1:0] u;
	logic [ID_W-1:0] root_id;

	assign a_ok   = 32'(a_q) < LIMIT;
	assign b_ok   = 32'(b_q) < LIMIT;
	assign a_pres = a_ok && present_q[a_q];
	assign b_pres = b_ok && present_q[b_q];
	assign top    = ID_W'(depth_q - 1'b1);
	assign v      = stk_v_q[top];
	assign nxt    = stk_n_q[top];
	assign root_id = root_q[ID_W-1:0];

	// neighbours at or above the resume point
	always_comb begin
		cand = '0;
		for (int i = 0; i < ID_SPAN; i++)
			cand[i] = adj_q[v][i] && (i >= 32'(nxt));
		found = |cand;
		u = '0;
		for (int i = ID_SPAN - 1; i >= 0; i--)
			if (cand[i]) u = ID_W'(i);
	end

	always_comb begin
		stat.root_done     = (32'(root_q) >= LIMIT);
		stat.stack_empty   = (depth_q == '0);
		stat.cycle         = (depth_q != '0) && found && visited_q[u] && on_path_q[u];
		// the word being shown is the final one of the list
		stat.emit_done     = ((emit_q + 1'b1) == fin_cnt_q);
		stat.none_finished = (fin_cnt_q == '0);
	end

	always_comb begin
		status     = status_q;
		vertex_out = '0;
		if (emit_q < fin_cnt_q)
			vertex_out = fin_q[ID_W'(fin_cnt_q - emit_q - 1'b1)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			a_q  <= vertex_a;
			b_q  <= vertex_b;
		end
		if (cmd.root_next && !stat.root_done && present_q[root_id] && !visited_q[root_id]
				&& stat.stack_empty) begin
			stk_v_q[0] <= root_id;
			stk_n_q[0] <= '0;
		end
		if (cmd.step && !stat.stack_empty) begin
			if (found) begin
				stk_n_q[top] <= {1'b0, u} + 1'b1;
				if (!visited_q[u] && depth_q < (ID_W+1)'(ID_SPAN)) begin
					stk_v_q[ID_W'(depth_q)] <= u;
					stk_n_q[ID_W'(depth_q)] <= '0;
				end
			end else if (fin_cnt_q < (ID_W+1)'(ID_SPAN)) begin
				fin_q[ID_W'(fin_cnt_q)] <= v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < ID_SPAN; i++) adj_q[i] <= '0;
			visited_q <= '0;
			on_path_q <= '0;
			depth_q   <= '0;
			fin_cnt_q <= '0;
			root_q    <= '0;
			emit_q    <= '0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.apply) begin
				status_q <= ST_OK;
				unique case (op_t'(op_q))
					OP_ADD_VERTEX: begin
						if (!a_ok) status_q <= ST_MISSING;
						else if (a_pres) status_q <= ST_EXISTS;
						else begin
							present_q[a_q] <= 1'b1;
							adj_q[a_q]     <= '0;
						end
					end
					OP_ADD_EDGE: begin
						if (!a_pres || !b_pres) status_q <= ST_MISSING;
						else adj_q[a_q][b_q] <= 1'b1;
					end
					default: status_q <= ST_OK;
				endcase
			end
			if (cmd.walk_init) begin
				visited_q <= '0;
				on_path_q <= '0;
				depth_q   <= '0;
				fin_cnt_q <= '0;
				root_q    <= '0;
				emit_q    <= '0;
				status_q  <= ST_OK;
			end
			if (cmd.root_next && !stat.root_done) begin
				root_q <= root_q + 1'b1;
				if (present_q[root_id] && !visited_q[root_id]) begin
					visited_q[root_id] <= 1'b1;
					on_path_q[root_id] <= 1'b1;
					depth_q <= depth_q + 1'b1;
				end
			end
			if (cmd.step && !stat.stack_empty) begin
				if (found) begin
					if (!visited_q[u]) begin
						visited_q[u] <= 1'b1;
						on_path_q[u] <= 1'b1;
						if (depth_q < (ID_W+1)'(ID_SPAN)) depth_q <= depth_q + 1'b1;
					end else if (on_path_q[u]) begin
						status_q <= ST_CYCLIC;
					end
				end else begin
					depth_q <= depth_q - 1'b1;
					on_path_q[v] <= 1'b0;
					if (fin_cnt_q < (ID_W+1)'(ID_SPAN)) fin_cnt_q <= fin_cnt_q + 1'b1;
				end
			end
			if (cmd.emit_next) emit_q <= emit_q + 1'b1;
		end
	end

endmodule

// ===== rtl/dfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer for loads, the depth-first walk and the result stream.
// ----------------------------------------------------------------------------
module dfs_ctrl import dfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] op,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      last,
	output logic      cyc_sel,
	output dfs_cmd_t  cmd,
	input  dfs_stat_t stat
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		last      = 1'b0;
		cyc_sel   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (op == OP_RUN) begin
						cmd.walk_init = 1'b1;
						state_d = S_ROOT;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				// store and status update here; the single result word follows
				cmd.apply = 1'b1;
				state_d = S_CYC;
				cyc_sel = 1'b1;
			end
			S_ROOT: begin
				if (stat.root_done) begin
					state_d = stat.none_finished ? S_IDLE : S_EMIT;
				end else begin
					cmd.root_next = 1'b1;
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (stat.stack_empty) state_d = S_ROOT;
				else if (stat.cycle) begin
					cmd.step = 1'b1;
					state_d = S_CYC;
				end else cmd.step = 1'b1;
			end
			S_CYC: begin
				// status word of an add, unused or cyclic run word
				out_valid = 1'b1;
				last      = 1'b1;
				cyc_sel   = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				last      = stat.emit_done;
				if (out_ready) begin
					cmd.emit_next = 1'b1;
					if (stat.emit_done) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/dfs_topological_sorter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topological_sorter_unit
// Graph loader with depth-first cycle check and topological sort.
// ----------------------------------------------------------------------------
// An add-vertex or add-edge word yields one result word. A run word walks
// the graph one stack step per cycle, with a root probe and an empty-stack
// check for every id plus one neighbour search on the stack top per step,
// then streams V result words for V present vertices, one per cycle while
// the output is ready (or one cyclic word). A new input word is taken only
// once every result of the previous word has been taken. The store is
// cleared by reset.
module dfs_topological_sorter_unit import dfs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input logic clk,
	input logic arst_n,
	dfs_in_if.sink    in_ch,
	dfs_out_if.source out_ch
);

	dfs_cmd_t  cmd;
	dfs_stat_t stat;
	logic      cyc_sel;
	logic [1:0] dp_status;
	logic [ID_W-1:0] dp_vertex;

	dfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.op        (in_ch.op),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.last      (out_ch.last),
		.cyc_sel   (cyc_sel),
		.cmd       (cmd),
		.stat      (stat)
	);

	dfs_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (in_ch.op),
		.vertex_a   (in_ch.vertex_a),
		.vertex_b   (in_ch.vertex_b),
		.status     (dp_status),
		.vertex_out (dp_vertex)
	);

	assign out_ch.status     = cyc_sel ? dp_status : ST_OK;
	assign out_ch.vertex_out = cyc_sel ? '0 : dp_vertex;

endmodule
